### rtl/button_debounce_autorepeat_macros.svh
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat: assertion macros
// Checks are clocked on clk and are off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bda: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define BDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bda: next-cycle check failed");

`endif

### rtl/bda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// Widths, codes and reset values shared by the debounce block and its channels.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int unsigned MS_W   = 16;
  localparam int unsigned BTN_W  = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 2;

  typedef logic [MS_W-1:0]   ms_t;
  typedef logic [BTN_W-1:0]  btn_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [1:0]        mode_t;

  // Button modes
  localparam mode_t MODE_RELEASED = 2'd0;
  localparam mode_t MODE_TRACKING = 2'd1;
  localparam mode_t MODE_PRESSED  = 2'd2;
  localparam mode_t MODE_REPEAT   = 2'd3;

  // Event kinds
  localparam kind_t EV_RELEASED = 2'd0;
  localparam kind_t EV_PRESSED  = 2'd1;
  localparam kind_t EV_REPEAT   = 2'd2;
  localparam kind_t EV_UNUSED   = 2'd3;

  // Register indexes
  localparam idx_t REG_DEBOUNCE     = 2'd0;
  localparam idx_t REG_REPEAT_DELAY = 2'd1;
  localparam idx_t REG_REPEAT_RATE  = 2'd2;
  localparam idx_t REG_BUTTON       = 2'd3;

  // Register reset values
  localparam ms_t  DEBOUNCE_RST     = 16'd20;
  localparam ms_t  REPEAT_DELAY_RST = 16'd500;
  localparam ms_t  REPEAT_RATE_RST  = 16'd100;
  localparam btn_t BUTTON_RST       = 8'd0;

  localparam ms_t  MS_MAX = 16'hFFFF;

endpackage

### rtl/bda_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_if
// Valid/ready channels for tick items and button events.
// ----------------------------------------------------------------------------

// Tick channel: sampled level and elapsed milliseconds
interface bda_tick_if;
  logic         valid;
  logic         ready;
  logic         level_pressed;
  bda_pkg::ms_t elapsed_ms;

  modport source (output valid, output level_pressed, output elapsed_ms, input ready);
  modport sink   (input valid, input level_pressed, input elapsed_ms, output ready);
endinterface

// Event channel: event kind and button identifier
interface bda_event_if;
  logic           valid;
  logic           ready;
  bda_pkg::kind_t event_kind;
  bda_pkg::btn_t  event_button;

  modport source (output valid, output event_kind, output event_button, input ready);
  modport sink   (input valid, input event_kind, input event_button, output ready);
endinterface

### rtl/button_debounce_autorepeat.sv
// Path: a tick accepted into the input register yields its event, if any, at the output
//   register (input register, then result register); an unaccepted event holds it back.
// Throughput: one tick per cycle unless an unaccepted event stalls it; the mode/countdown
//   update is a single 16-bit compare and add/subtract between the two registers.
// Reset: synchronous on rst_n low; registers return to 20/500/100/0 ms/id,
//   mode to released, countdown to zero, both stages empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_autorepeat
// Debounces a sampled button level and emits pressed, auto-repeat and
// released events, one optional event per tick.
// ----------------------------------------------------------------------------
`include "button_debounce_autorepeat_macros.svh"

module button_debounce_autorepeat (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  bda_pkg::idx_t       cfg_index,
  input  bda_pkg::ms_t        cfg_wdata,
  bda_tick_if.sink            in_tick,
  bda_event_if.source         out_evt
);

  // Configuration registers
  bda_pkg::ms_t  debounce_r;
  bda_pkg::ms_t  repeat_delay_r;
  bda_pkg::ms_t  repeat_rate_r;
  bda_pkg::btn_t button_r;

  // Input stage
  logic          s1_valid_r;
  logic          s1_level_r;
  bda_pkg::ms_t  s1_elapsed_r;
  logic          s1_fire;
  logic          in_ready;

  // Button state
  bda_pkg::mode_t mode_r, mode_nxt;
  bda_pkg::ms_t   countdown_r, countdown_nxt;

  // Result stage
  logic           out_valid_r, out_valid_nxt;
  bda_pkg::kind_t out_kind_r;
  bda_pkg::btn_t  out_button_r;

  logic           emit;
  bda_pkg::kind_t emit_kind;
  logic           held;
  logic [bda_pkg::MS_W:0] repeat_sum;

  // Advance the input stage when the result slot is free or draining
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_evt.ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_tick.ready = in_ready;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= bda_pkg::DEBOUNCE_RST;
      repeat_delay_r <= bda_pkg::REPEAT_DELAY_RST;
      repeat_rate_r  <= bda_pkg::REPEAT_RATE_RST;
      button_r       <= bda_pkg::BUTTON_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bda_pkg::REG_DEBOUNCE:     debounce_r     <= cfg_wdata;
        bda_pkg::REG_REPEAT_DELAY: repeat_delay_r <= cfg_wdata;
        bda_pkg::REG_REPEAT_RATE:  repeat_rate_r  <= cfg_wdata;
        bda_pkg::REG_BUTTON:       button_r       <= cfg_wdata[bda_pkg::BTN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture a tick transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_tick.valid) begin
      s1_level_r   <= in_tick.level_pressed;
      s1_elapsed_r <= in_tick.elapsed_ms;
    end
  end

  // Step the mode and countdown for the tick in the input stage
  assign held       = (mode_r != bda_pkg::MODE_RELEASED);
  assign repeat_sum = {1'b0, countdown_r} + {1'b0, repeat_rate_r};

  always_comb begin
    mode_nxt      = mode_r;
    countdown_nxt = countdown_r;
    emit          = 1'b0;
    emit_kind     = bda_pkg::EV_RELEASED;
    if (s1_level_r != held) begin
      if (s1_level_r) begin
        countdown_nxt = debounce_r;
        mode_nxt      = bda_pkg::MODE_TRACKING;
      end else begin
        // Release after a confirmed press reports; release while tracking is silent
        mode_nxt  = bda_pkg::MODE_RELEASED;
        emit      = (mode_r != bda_pkg::MODE_TRACKING);
        emit_kind = bda_pkg::EV_RELEASED;
      end
    end else if (held) begin
      if (s1_elapsed_r < countdown_r) begin
        countdown_nxt = countdown_r - s1_elapsed_r;
      end else begin
        emit = 1'b1;
        case (mode_r)
          bda_pkg::MODE_TRACKING: begin
            mode_nxt      = bda_pkg::MODE_PRESSED;
            countdown_nxt = repeat_delay_r;
            emit_kind     = bda_pkg::EV_PRESSED;
          end
          bda_pkg::MODE_PRESSED: begin
            mode_nxt      = bda_pkg::MODE_REPEAT;
            countdown_nxt = repeat_rate_r;
            emit_kind     = bda_pkg::EV_REPEAT;
          end
          default: begin
            // Add the rate to the leftover count, saturating at full scale
            countdown_nxt = repeat_sum[bda_pkg::MS_W] ? bda_pkg::MS_MAX
                                                      : repeat_sum[bda_pkg::MS_W-1:0];
            emit_kind     = bda_pkg::EV_REPEAT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= bda_pkg::MODE_RELEASED;
      countdown_r <= '0;
    end else if (s1_fire) begin
      mode_r      <= mode_nxt;
      countdown_r <= countdown_nxt;
    end
  end

  // Hold a result until its transfer, load a new one on a step
  always_comb begin
    if (s1_fire) begin
      out_valid_nxt = emit;
    end else if (out_evt.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_kind_r   <= emit_kind;
      out_button_r <= button_r;
    end
  end

  assign out_evt.valid        = out_valid_r;
  assign out_evt.event_kind   = out_kind_r;
  assign out_evt.event_button = out_button_r;

  // Assertions
  `BDA_ASSERT_NOW(a_stall_has_item, !in_ready, s1_valid_r)
  `BDA_ASSERT_NEXT(a_emit_lands, s1_fire && emit, out_valid_r)
  `BDA_ASSERT_NOW(a_press_from_tracking, s1_fire && emit && emit_kind == bda_pkg::EV_PRESSED,
                  mode_r == bda_pkg::MODE_TRACKING)
  `BDA_ASSERT_NEXT(a_idle_stays_released,
                   s1_fire && !s1_level_r && mode_r == bda_pkg::MODE_RELEASED,
                   mode_r == bda_pkg::MODE_RELEASED)
  `BDA_ASSERT_NOW(a_no_unused_kind, out_valid_r, out_kind_r != bda_pkg::EV_UNUSED)

endmodule

### sim/bda_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_event_checker
// Watches the configuration port and both channels of the debounce block,
// keeps its own mode and countdown, and checks every event transfer
// in order against the events that the accepted ticks should cause.
// ----------------------------------------------------------------------------
module bda_event_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  bda_pkg::idx_t cfg_index,
  input  bda_pkg::ms_t  cfg_wdata,
  bda_tick_if           tick,
  bda_event_if          evt,
  output int unsigned   events_owed,
  output int unsigned   mismatches
);

  typedef struct packed {
    bda_pkg::kind_t kind;
    bda_pkg::btn_t  button;
  } button_event_t;

  // Shadow registers
  bda_pkg::ms_t  debounce_ms;
  bda_pkg::ms_t  repeat_delay_ms;
  bda_pkg::ms_t  repeat_rate_ms;
  bda_pkg::btn_t button_id;

  // Shadow state
  bda_pkg::mode_t btn_mode;
  bda_pkg::ms_t   countdown;

  button_event_t awaited_events[$];

  // Advance the button state by one tick; return 1 when an event is due
  function automatic bit advance_button(input logic lvl, input bda_pkg::ms_t ms,
                                        output bda_pkg::kind_t kind);
    logic [bda_pkg::MS_W:0] sum;
    kind = bda_pkg::EV_RELEASED;
    if (lvl != (btn_mode != bda_pkg::MODE_RELEASED)) begin
      if (lvl) begin
        countdown = debounce_ms;
        btn_mode  = bda_pkg::MODE_TRACKING;
        return 1'b0;
      end
      // a bounce before confirmation ends silently
      if (btn_mode == bda_pkg::MODE_TRACKING) begin
        btn_mode = bda_pkg::MODE_RELEASED;
        return 1'b0;
      end
      btn_mode = bda_pkg::MODE_RELEASED;
      kind     = bda_pkg::EV_RELEASED;
      return 1'b1;
    end
    if (btn_mode == bda_pkg::MODE_RELEASED) return 1'b0;
    if (ms < countdown) begin
      countdown = countdown - ms;
      return 1'b0;
    end
    case (btn_mode)
      bda_pkg::MODE_TRACKING: begin
        btn_mode  = bda_pkg::MODE_PRESSED;
        countdown = repeat_delay_ms;
        kind      = bda_pkg::EV_PRESSED;
      end
      bda_pkg::MODE_PRESSED: begin
        btn_mode  = bda_pkg::MODE_REPEAT;
        countdown = repeat_rate_ms;
        kind      = bda_pkg::EV_REPEAT;
      end
      default: begin
        // later expiries accumulate the rate, clamped at the top
        sum       = {1'b0, countdown} + {1'b0, repeat_rate_ms};
        countdown = sum[bda_pkg::MS_W] ? bda_pkg::MS_MAX : sum[bda_pkg::MS_W-1:0];
        kind      = bda_pkg::EV_REPEAT;
      end
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    button_event_t  got;
    button_event_t  want;
    bda_pkg::kind_t kind;
    if (!rst_n) begin
      debounce_ms     = bda_pkg::DEBOUNCE_RST;
      repeat_delay_ms = bda_pkg::REPEAT_DELAY_RST;
      repeat_rate_ms  = bda_pkg::REPEAT_RATE_RST;
      button_id       = bda_pkg::BUTTON_RST;
      btn_mode        = bda_pkg::MODE_RELEASED;
      countdown       = '0;
      mismatches      = 0;
      awaited_events.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          bda_pkg::REG_DEBOUNCE:     debounce_ms     = cfg_wdata;
          bda_pkg::REG_REPEAT_DELAY: repeat_delay_ms = cfg_wdata;
          bda_pkg::REG_REPEAT_RATE:  repeat_rate_ms  = cfg_wdata;
          bda_pkg::REG_BUTTON:       button_id       = cfg_wdata[bda_pkg::BTN_W-1:0];
          default: ;
        endcase
      end

      // Compare each event transfer with the oldest awaited event
      if (evt.valid && evt.ready) begin
        got.kind   = evt.event_kind;
        got.button = evt.event_button;
        if (awaited_events.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected event: expected none, got kind %0d button %0d",
                   $time, got.kind, got.button);
        end else begin
          want = awaited_events.pop_front();
          if (got.kind !== want.kind) begin
            mismatches++;
            $display("%0t: event kind mismatch: expected %0d, got %0d",
                     $time, want.kind, got.kind);
          end
          if (got.button !== want.button) begin
            mismatches++;
            $display("%0t: event button mismatch: expected %0d, got %0d",
                     $time, want.button, got.button);
          end
        end
      end

      // Predict from each tick transfer
      if (tick.valid && tick.ready) begin
        if (advance_button(tick.level_pressed, tick.elapsed_ms, kind)) begin
          want.kind   = kind;
          want.button = button_id;
          awaited_events.push_back(want);
        end
      end
    end
    events_owed <= awaited_events.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives ticks and register settings into the debounce block: a directed
// pass over presses, bounces, zero and saturating countdowns, then random
// press/hold/release sequences with bounce noise under several settings,
// with random gaps on both channels. The checker reports mismatches.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned PHASE_ITEMS    = 250;
  localparam int unsigned RANDOM_PHASES  = 6;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  bda_pkg::idx_t cfg_index;
  bda_pkg::ms_t  cfg_wdata;
  logic          calm;
  int unsigned   events_owed;
  int unsigned   mismatches;

  bda_tick_if  tick_ch();
  bda_event_if evt_ch();

  button_debounce_autorepeat i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tick  (tick_ch),
    .out_evt  (evt_ch)
  );

  bda_event_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .tick       (tick_ch),
    .evt        (evt_ch),
    .events_owed(events_owed),
    .mismatches (mismatches)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the event channel in about 7 percent of cycles, never while calm
  initial begin
    evt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      evt_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // Abort when no transfer happens for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (tick_ch.valid && tick_ch.ready) || (evt_ch.valid && evt_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one tick, with an occasional gap first, and hold it until transfer
  task automatic send_tick(input logic lvl, input bda_pkg::ms_t ms);
    while (!calm && $urandom_range(0, 99) < 7) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.level_pressed <= lvl;
    tick_ch.elapsed_ms    <= ms;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  // Drop valid, drain owed events, then let the pipeline empty
  task automatic settle();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (events_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; hold the enable until the last
  task automatic apply_settings(input bda_pkg::ms_t debounce, input bda_pkg::ms_t delay,
                                input bda_pkg::ms_t rate, input bda_pkg::ms_t button_word);
    cfg_we    <= 1'b1;
    cfg_index <= bda_pkg::REG_DEBOUNCE;
    cfg_wdata <= debounce;
    @(posedge clk);
    cfg_index <= bda_pkg::REG_REPEAT_DELAY;
    cfg_wdata <= delay;
    @(posedge clk);
    cfg_index <= bda_pkg::REG_REPEAT_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= bda_pkg::REG_BUTTON;
    cfg_wdata <= button_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Register value: mostly short times so that expiries happen often
  function automatic bda_pkg::ms_t pick_setting();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 25) return bda_pkg::MS_MAX;
    if (roll < 75) return bda_pkg::ms_t'($urandom_range(1, 40));
    return bda_pkg::ms_t'($urandom_range(0, 65535));
  endfunction

  // Button word: upper bits are mostly random and must be dropped by the block
  function automatic bda_pkg::ms_t pick_button_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return 16'h00FF;
    return bda_pkg::ms_t'($urandom_range(0, 65535));
  endfunction

  function automatic bda_pkg::ms_t pick_elapsed();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 35) return bda_pkg::ms_t'($urandom_range(1, 8));
    if (roll < 60) return bda_pkg::ms_t'($urandom_range(0, 64));
    if (roll < 75) return bda_pkg::ms_t'($urandom_range(0, 1023));
    if (roll < 90) return bda_pkg::ms_t'($urandom_range(0, 65535));
    return bda_pkg::MS_MAX;
  endfunction

  // Mostly clean press/hold/release sequences, the rest bounce noise
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned hold;
    int unsigned j;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        hold = $urandom_range(1, 24);
        send_tick(1'b1, pick_elapsed());
        for (j = 0; j < hold; j++) send_tick(1'b1, pick_elapsed());
        send_tick(1'b0, pick_elapsed());
        sent += hold + 2;
      end else begin
        hold = $urandom_range(1, 4);
        for (j = 0; j < hold; j++) send_tick(logic'($urandom_range(0, 1)), pick_elapsed());
        sent += hold;
      end
    end
  endtask

  initial begin
    int unsigned phase;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= bda_pkg::REG_DEBOUNCE;
    cfg_wdata             <= '0;
    calm                  <= 1'b0;
    tick_ch.valid         <= 1'b0;
    tick_ch.level_pressed <= 1'b0;
    tick_ch.elapsed_ms    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle release ticks, then a full press cycle
    send_tick(1'b0, '0);
    send_tick(1'b0, bda_pkg::MS_MAX);
    send_tick(1'b1, '0);
    send_tick(1'b1, 16'd19);
    send_tick(1'b1, 16'd1);
    send_tick(1'b1, 16'd499);
    send_tick(1'b1, bda_pkg::MS_MAX);
    send_tick(1'b1, 16'd100);
    send_tick(1'b0, '0);
    // Bounce while tracking: no event
    send_tick(1'b1, 16'd5);
    send_tick(1'b0, '0);
    settle();

    // Zero countdowns expire at once; the repeat sum clamps at the top
    apply_settings('0, '0, bda_pkg::MS_MAX, 16'hFFFF);
    send_tick(1'b1, '0);
    send_tick(1'b1, '0);
    send_tick(1'b1, '0);
    send_tick(1'b1, '0);
    send_tick(1'b1, bda_pkg::MS_MAX);
    send_tick(1'b1, bda_pkg::MS_MAX);
    send_tick(1'b0, '0);
    settle();

    // Longest delay, zero rate: once repeating, every held tick repeats
    apply_settings(16'd1, bda_pkg::MS_MAX, '0, 16'h005A);
    send_tick(1'b1, '0);
    send_tick(1'b1, 16'd1);
    send_tick(1'b1, bda_pkg::MS_MAX);
    send_tick(1'b1, '0);
    send_tick(1'b0, '0);
    settle();

    // Random settings; one phase runs without any idling
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_settings(pick_setting(), pick_setting(), pick_setting(), pick_button_word());
      calm <= (phase == 2);
      run_random_phase(PHASE_ITEMS);
      settle();
    end

    if (mismatches == 0 && events_owed == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bda_pkg.sv
rtl/bda_if.sv
rtl/button_debounce_autorepeat.sv
sim/bda_event_checker.sv
sim/tb.sv
